FILE: rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another one in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/arm_jac_pkg.sv
// Types, constants and arithmetic helpers for the arm Jacobian pipeline.
`default_nettype none
package arm_jac_pkg;
    typedef logic        [15:0] phase_t;
    typedef logic signed [15:0] angle_t;
    typedef logic signed [16:0] sc_t;
    typedef logic signed [33:0] q30_t;
    typedef logic signed [17:0] ent_t;
    typedef ent_t [5:0]         ent_row_t;
    typedef q30_t [5:0]         q30_row_t;

    localparam int ROWS   = 6;
    localparam int IN_W   = 80;
    localparam int OUT_W  = 112;
    localparam logic [15:0] TOOL_RESET = 16'd17845;
    localparam sc_t PHASE_GAIN = 17'sd41722;
    localparam sc_t LEN_A = 17'sd7157;
    localparam sc_t LEN_B = 17'sd27853;
    localparam sc_t LEN_C = 17'sd25690;
    localparam sc_t LEN_D = 17'sd6206;
    localparam q30_t ONE_Q30 = 34'sd1073741824;
    localparam phase_t QUARTER = 16'h4000;
    localparam logic [2:0] LAST_ROW = 3'd5;

    function automatic phase_t to_phase(angle_t a);
        logic signed [33:0] p;
        p = a * PHASE_GAIN;
        p = p + 34'sd16384;
        return p[30:15];
    endfunction

    function automatic q30_t mul(sc_t a, sc_t b);
        return q30_t'(a) * q30_t'(b);
    endfunction

    // Q30 times Q14, rounded to Q30
    function automatic q30_t mq(q30_t a, sc_t b);
        logic signed [50:0] p;
        p = 51'(a) * 51'(b);
        p = p + 51'sd8192;
        return $signed(p[47:14]);
    endfunction

    function automatic ent_t to_out(q30_t q);
        logic signed [34:0] s;
        logic signed [18:0] v;
        s = 35'(q) + 35'sd32768;
        v = $signed(s[34:16]);
        if (v > 19'sd131071)
            v = 19'sd131071;
        else if (v < -19'sd131072)
            v = -19'sd131072;
        return v[17:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/arm_jac_sin.sv
// Four-stage pipelined quarter-wave polynomial sine in Q14.
`default_nettype none
module arm_jac_sin (
    input  wire                  clk,
    input  wire                  en,
    input  wire arm_jac_pkg::phase_t ph,
    output arm_jac_pkg::sc_t     sin_val
);
    import arm_jac_pkg::*;

    logic [1:0]  quad;
    logic [14:0] z;
    logic [29:0] zz;
    logic [25:0] zk;
    logic [28:0] zt;
    logic [29:0] zs;

    logic [14:0] za_reg, zb_reg, zc_reg;
    logic [1:0]  qa_reg, qb_reg, qc_reg;
    logic [14:0] z2a_reg, z2b_reg;
    logic [14:0] t1_reg;
    logic [15:0] t2_reg;
    sc_t         s_reg;

    assign quad = ph[15:14];
    assign z    = quad[0] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    assign zz   = z * z;
    assign zk   = z2a_reg * 26'd2320;
    assign zt   = z2b_reg * t1_reg;
    assign zs   = zc_reg * t2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            za_reg  <= z;
            qa_reg  <= quad;
            z2a_reg <= zz[28:14];
            zb_reg  <= za_reg;
            qb_reg  <= qa_reg;
            z2b_reg <= z2a_reg;
            t1_reg  <= 15'(15'd21024 - zk[25:14]);
            zc_reg  <= zb_reg;
            qc_reg  <= qb_reg;
            t2_reg  <= 16'(16'd51472 - zt[28:14]);
            s_reg   <= qc_reg[1] ? -$signed({2'b00, zs[29:15]}) : $signed({2'b00, zs[29:15]});
        end
    end

    assign sin_val = s_reg;
endmodule
`default_nettype wire

FILE: rtl/six_axis_arm_jacobian.sv
// Top level: six-axis arm geometric Jacobian, one matrix per joint-angle item.
`default_nettype none
// One input item (five joint angles) yields six output items, one Jacobian row each,
// rows 0 to 5 in order, tlast on row 5. The pipeline runs 12 register stages from
// input to output register: phase, joint sums, a four-stage sine/cosine, four product
// and sum stages, the matrix buffer and the output register. Items enter every cycle
// while the matrix buffer is empty; once it holds a matrix, a new item is taken only
// when the buffer hands its last row to the output register, so throughput is bound
// by the single row-wide output channel, six rows per item, and by m_tready stalls.
// The user writes tool_length only while idle; the block itself does not enforce it.
module six_axis_arm_jacobian (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          tool_length_we,
    input  wire [15:0]                   tool_length_wdata,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // angle_base, angle_shoulder, angle_elbow, angle_wrist_one, angle_wrist_two
    input  wire [arm_jac_pkg::IN_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // row_number, entry_col0 .. entry_col5, one zero pad bit
    output logic [arm_jac_pkg::OUT_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import arm_jac_pkg::*;

    logic        en;
    logic        load;
    logic [15:0] tool_length_reg;

    // stage valid bits
    logic       v1_reg, v2_reg;
    logic [3:0] sv_reg;
    logic       p1v_reg, p2v_reg, p3v_reg, p4v_reg;
    logic       mat_valid_reg;
    logic [2:0] row_reg;
    logic       out_valid_reg;
    logic [2:0] out_row_reg;
    ent_row_t   out_ent_reg;

    phase_t ph_reg [5];
    phase_t tp_reg [5];
    phase_t sin_in [10];
    sc_t    trig   [10];

    sc_t s1, c1, s2, c2, s5, c5, s23, c23, s234, c234, len_s;

    // product stage 1
    q30_t ls5_reg, lc5_reg, lac1_reg, las1_reg, lbs2_reg, lbc2_reg;
    q30_t lcs23_reg, lcc23_reg, ldc234_reg, lds234_reg;
    q30_t c1s234_reg, s1s234_reg, c5s1_reg, c1c234_reg, s1c234_reg, s5s234_reg, c1c5_reg;
    sc_t  s1a_reg, c1a_reg, s5a_reg, c234a_reg, s234a_reg;

    // product stage 2
    q30_t a_ls5s234_reg, a_ls5c234_reg, a_ls5c1_reg, a_lc5s1_reg, a_lc5c1_reg;
    q30_t a_lc5s234_reg, a_ls5s1_reg, a_m35_reg, a_m45_reg;
    q30_t lac1b_reg, las1b_reg, lbs2b_reg, lbc2b_reg, lcs23b_reg, lcc23b_reg;
    q30_t ldc234b_reg, lds234b_reg;
    q30_t c1s234b_reg, s1s234b_reg, c5s1b_reg, s5s234b_reg, c1c5b_reg;
    sc_t  s1b_reg, c1b_reg, c234b_reg;

    // sum stage
    q30_t q3_next, r3_next, q2_next, q1_next, r2_next, pp_next;
    q30_t q1_reg, q2_reg, q3_reg, r2_reg, r3_reg, pp_reg;
    q30_t b_j14_reg, b_m04_reg;
    q30_t lac1c_reg, las1c_reg, a_lc5c1c_reg, a_lc5s1c_reg, a_ls5c1c_reg, a_ls5s1c_reg;
    q30_t a_lc5s234c_reg, a_m35c_reg, a_m45c_reg;
    q30_t c1s234c_reg, s1s234c_reg, c5s1c_reg, s5s234c_reg, c1c5c_reg;
    sc_t  s1c_reg, c1c_reg, c234c_reg;

    q30_row_t m4_next [ROWS];
    q30_row_t m4_reg  [ROWS];
    ent_row_t mat_reg [ROWS];

    assign load     = mat_valid_reg && (!out_valid_reg || m_tready);
    assign en       = !mat_valid_reg || (load && row_reg == LAST_ROW);
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tool_length_reg <= TOOL_RESET;
        else if (tool_length_we)
            tool_length_reg <= tool_length_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sv_reg        <= '0;
            p1v_reg       <= 1'b0;
            p2v_reg       <= 1'b0;
            p3v_reg       <= 1'b0;
            p4v_reg       <= 1'b0;
            mat_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            sv_reg        <= {sv_reg[2:0], v2_reg};
            p1v_reg       <= sv_reg[3];
            p2v_reg       <= p1v_reg;
            p3v_reg       <= p2v_reg;
            p4v_reg       <= p3v_reg;
            mat_valid_reg <= p4v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 5; k++)
                ph_reg[k] <= to_phase($signed(s_tdata[16*k +: 16]));
            tp_reg[0] <= ph_reg[0];
            tp_reg[1] <= ph_reg[1];
            tp_reg[2] <= ph_reg[4];
            tp_reg[3] <= ph_reg[1] + ph_reg[2];
            tp_reg[4] <= ph_reg[1] + ph_reg[2] + ph_reg[3];
        end
    end

    // even units give sine, odd units cosine
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            sin_in[2*k]   = tp_reg[k];
            sin_in[2*k+1] = tp_reg[k] + QUARTER;
        end
    end

    for (genvar g = 0; g < 10; g++)
    begin : g_trig
        arm_jac_sin u_sin (
            .clk     (clk),
            .en      (en),
            .ph      (sin_in[g]),
            .sin_val (trig[g])
        );
    end

    assign s1    = trig[0];
    assign c1    = trig[1];
    assign s2    = trig[2];
    assign c2    = trig[3];
    assign s5    = trig[4];
    assign c5    = trig[5];
    assign s23   = trig[6];
    assign c23   = trig[7];
    assign s234  = trig[8];
    assign c234  = trig[9];
    assign len_s = $signed({1'b0, tool_length_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ls5_reg    <= mul(len_s, s5);
            lc5_reg    <= mul(len_s, c5);
            lac1_reg   <= mul(LEN_A, c1);
            las1_reg   <= mul(LEN_A, s1);
            lbs2_reg   <= mul(LEN_B, s2);
            lbc2_reg   <= mul(LEN_B, c2);
            lcs23_reg  <= mul(LEN_C, s23);
            lcc23_reg  <= mul(LEN_C, c23);
            ldc234_reg <= mul(LEN_D, c234);
            lds234_reg <= mul(LEN_D, s234);
            c1s234_reg <= mul(c1, s234) <<< 2;
            s1s234_reg <= mul(s1, s234) <<< 2;
            c5s1_reg   <= mul(c5, s1) <<< 2;
            c1c234_reg <= mul(c1, c234) <<< 2;
            s1c234_reg <= mul(s1, c234) <<< 2;
            s5s234_reg <= mul(s5, s234) <<< 2;
            c1c5_reg   <= mul(c1, c5) <<< 2;
            s1a_reg    <= s1;
            c1a_reg    <= c1;
            s5a_reg    <= s5;
            c234a_reg  <= c234;
            s234a_reg  <= s234;

            a_ls5s234_reg <= mq(ls5_reg, s234a_reg);
            a_ls5c234_reg <= mq(ls5_reg, c234a_reg);
            a_ls5c1_reg   <= mq(ls5_reg, c1a_reg);
            a_ls5s1_reg   <= mq(ls5_reg, s1a_reg);
            a_lc5s1_reg   <= mq(lc5_reg, s1a_reg);
            a_lc5c1_reg   <= mq(lc5_reg, c1a_reg);
            a_lc5s234_reg <= mq(lc5_reg, s234a_reg);
            a_m35_reg     <= mq(c1c234_reg, s5a_reg);
            a_m45_reg     <= mq(s1c234_reg, s5a_reg);
            lac1b_reg     <= lac1_reg;
            las1b_reg     <= las1_reg;
            lbs2b_reg     <= lbs2_reg;
            lbc2b_reg     <= lbc2_reg;
            lcs23b_reg    <= lcs23_reg;
            lcc23b_reg    <= lcc23_reg;
            ldc234b_reg   <= ldc234_reg;
            lds234b_reg   <= lds234_reg;
            c1s234b_reg   <= c1s234_reg;
            s1s234b_reg   <= s1s234_reg;
            c5s1b_reg     <= c5s1_reg;
            s5s234b_reg   <= s5s234_reg;
            c1c5b_reg     <= c1c5_reg;
            s1b_reg       <= s1a_reg;
            c1b_reg       <= c1a_reg;
            c234b_reg     <= c234a_reg;
        end
    end

    always_comb
    begin
        q3_next = ldc234b_reg + a_ls5s234_reg;
        r3_next = lds234b_reg - a_ls5c234_reg;
        q2_next = lcs23b_reg + q3_next;
        q1_next = lbs2b_reg + q2_next;
        r2_next = r3_next - lcc23b_reg;
        pp_next = r2_next - lbc2b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg         <= q1_next;
            q2_reg         <= q2_next;
            q3_reg         <= q3_next;
            r2_reg         <= r2_next;
            r3_reg         <= r3_next;
            pp_reg         <= pp_next;
            b_j14_reg      <= mq(a_lc5s1_reg, c234b_reg);
            b_m04_reg      <= mq(a_lc5c1_reg, c234b_reg);
            lac1c_reg      <= lac1b_reg;
            las1c_reg      <= las1b_reg;
            a_lc5c1c_reg   <= a_lc5c1_reg;
            a_lc5s1c_reg   <= a_lc5s1_reg;
            a_ls5c1c_reg   <= a_ls5c1_reg;
            a_ls5s1c_reg   <= a_ls5s1_reg;
            a_lc5s234c_reg <= a_lc5s234_reg;
            a_m35c_reg     <= a_m35_reg;
            a_m45c_reg     <= a_m45_reg;
            c1s234c_reg    <= c1s234b_reg;
            s1s234c_reg    <= s1s234b_reg;
            c5s1c_reg      <= c5s1b_reg;
            s5s234c_reg    <= s5s234b_reg;
            c1c5c_reg      <= c1c5b_reg;
            s1c_reg        <= s1b_reg;
            c1c_reg        <= c1b_reg;
            c234c_reg      <= c234b_reg;
        end
    end

    always_comb
    begin
        m4_next[0][0] = lac1c_reg + a_lc5c1c_reg - mq(pp_reg, s1c_reg);
        m4_next[0][1] = mq(q1_reg, c1c_reg);
        m4_next[0][2] = mq(q2_reg, c1c_reg);
        m4_next[0][3] = mq(q3_reg, c1c_reg);
        m4_next[0][4] = -(a_ls5s1c_reg + b_m04_reg);
        m4_next[0][5] = '0;

        m4_next[1][0] = las1c_reg + a_lc5s1c_reg + mq(pp_reg, c1c_reg);
        m4_next[1][1] = mq(q1_reg, s1c_reg);
        m4_next[1][2] = mq(q2_reg, s1c_reg);
        m4_next[1][3] = mq(q3_reg, s1c_reg);
        m4_next[1][4] = a_ls5c1c_reg - b_j14_reg;
        m4_next[1][5] = '0;

        m4_next[2][0] = '0;
        m4_next[2][1] = pp_reg;
        m4_next[2][2] = r2_reg;
        m4_next[2][3] = r3_reg;
        m4_next[2][4] = -a_lc5s234c_reg;
        m4_next[2][5] = '0;

        m4_next[3][0] = '0;
        m4_next[3][1] = q30_t'(s1c_reg) <<< 16;
        m4_next[3][2] = q30_t'(s1c_reg) <<< 16;
        m4_next[3][3] = q30_t'(s1c_reg) <<< 16;
        m4_next[3][4] = c1s234c_reg;
        m4_next[3][5] = c5s1c_reg - a_m35c_reg;

        m4_next[4][0] = '0;
        m4_next[4][1] = -(q30_t'(c1c_reg) <<< 16);
        m4_next[4][2] = -(q30_t'(c1c_reg) <<< 16);
        m4_next[4][3] = -(q30_t'(c1c_reg) <<< 16);
        m4_next[4][4] = s1s234c_reg;
        m4_next[4][5] = -a_m45c_reg - c1c5c_reg;

        m4_next[5][0] = ONE_Q30;
        m4_next[5][1] = '0;
        m4_next[5][2] = '0;
        m4_next[5][3] = '0;
        m4_next[5][4] = -(q30_t'(c234c_reg) <<< 16);
        m4_next[5][5] = -s5s234c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                m4_reg[r] <= m4_next[r];
                for (int c = 0; c < 6; c++)
                    mat_reg[r][c] <= to_out(m4_reg[r][c]);
            end
        end
    end

    // advance one row per taken slot; restart at row 0 with each new matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                row_reg <= (row_reg == LAST_ROW) ? 3'd0 : row_reg + 3'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_row_reg <= row_reg;
            out_ent_reg <= mat_reg[row_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ent_reg[5], out_ent_reg[4], out_ent_reg[3],
                       out_ent_reg[2], out_ent_reg[1], out_ent_reg[0], out_row_reg};
    assign m_tlast  = (out_row_reg == LAST_ROW);
endmodule
`default_nettype wire

FILE: rtl/arm_jac_chk.sv
// Port-level checker for the arm Jacobian block and its bind.
`default_nettype none
`include "assert_macros.svh"
module arm_jac_chk (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [arm_jac_pkg::OUT_W-1:0]  m_tdata,
    input wire                           m_tlast
);
    `ASSERT_ALWAYS(a_row_range, !m_tvalid || m_tdata[2:0] <= 3'd5, "row number out of range")
    `ASSERT_ALWAYS(a_last_row, !m_tvalid || (m_tlast == (m_tdata[2:0] == 3'd5)), "tlast not on row 5")
    `ASSERT_NEXT(a_row_seq, m_tvalid && m_tready && !m_tlast, !m_tvalid || m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1, "rows out of order")
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled item changed")
    `ASSERT_NEXT(a_no_take_mid, m_tvalid && !m_tlast && !m_tready && !s_tvalid, !s_tready || !m_tvalid || !m_tlast, "input taken mid matrix")
endmodule

bind six_axis_arm_jacobian arm_jac_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
